[hdl/arq_flush_retransmit_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the retransmit scheduler
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ARQ_FLUSH_RETRANSMIT_SCHEDULER_DEFINES_SVH
`define ARQ_FLUSH_RETRANSMIT_SCHEDULER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define ARQFRS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ARQFRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/arqfrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Retransmit scheduler package
// Payload types, register indexes, action codes and protocol constants.
// ----------------------------------------------------------------------------
package arqfrs_pkg;

	// Action codes carried in the input beat.
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_SEG  = 2'd1;
	localparam logic [1:0] ACT_END  = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_NO_DELAY      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLUSH_IVL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_ACKS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NO_CONGESTION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_WINDOW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_SENDS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MSS           = 3'd6;

	// Register reset values and flush interval bounds.
	localparam logic [12:0] FLUSH_IVL_RST   = 13'd100;
	localparam logic [12:0] FLUSH_IVL_MIN   = 13'd10;
	localparam logic [12:0] FLUSH_IVL_MAX   = 13'd5000;
	localparam logic [15:0] SEND_WINDOW_RST = 16'd32;
	localparam logic [7:0]  DEAD_SENDS_RST  = 8'd20;
	localparam logic [15:0] MSS_RST         = 16'd1376;

	// Timer and window constants.
	localparam int signed   RESYNC_MS      = 10000;
	localparam logic [31:0] NEXT_FLUSH_RST = 32'd100;
	localparam logic [17:0] PROBE_FIRST_MS = 18'd7000;
	localparam logic [17:0] PROBE_MAX_MS   = 18'd120000;
	localparam logic [15:0] THRESH_FLOOR   = 16'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_ms;
		logic [15:0] remote_window;
		logic [7:0]  seg_send_count;
		logic [31:0] seg_timeout;
		logic [31:0] seg_resend_time;
		logic [7:0]  seg_skip_acks;
		logic [15:0] base_timeout;
		logic [15:0] in_flight;
	} item_t;

	typedef struct packed {
		logic        flush_now;
		logic        ask_window_probe;
		logic        need_send;
		logic [7:0]  new_send_count;
		logic [31:0] new_timeout;
		logic [31:0] new_resend_time;
		logic [7:0]  new_skip_acks;
		logic        link_dead;
		logic [15:0] effective_window;
		logic [15:0] congestion_window;
		logic [15:0] slow_start_threshold;
		logic [31:0] byte_credit;
	} result_t;

	// Context the segment evaluator needs from the scheduler state.
	typedef struct packed {
		logic        started;
		logic [31:0] now;
		logic        no_delay;
		logic [7:0]  fast_acks;
		logic [7:0]  dead_sends;
	} seg_ctl_t;

	// Segment decision handed back to the scheduler.
	typedef struct packed {
		logic        send;
		logic [7:0]  cnt;
		logic [31:0] tmo;
		logic [31:0] due;
		logic [7:0]  skip;
		logic        loss;
		logic        fast;
		logic        dead;
	} seg_res_t;

endpackage

[hdl/arqfrs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Retransmit scheduler channels
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface arqfrs_item_if;
	logic                valid;
	logic                ready;
	arqfrs_pkg::item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface arqfrs_result_if;
	logic                valid;
	logic                ready;
	arqfrs_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface arqfrs_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [arqfrs_pkg::CFG_IDX_W-1:0]  index;
	logic [arqfrs_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/arqfrs_seg_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment send decision
// Decides first send, timeout resend or fast resend for one segment and
// forms its updated counters.
// ----------------------------------------------------------------------------
module arqfrs_seg_eval (
	input  arqfrs_pkg::item_t    item,
	input  arqfrs_pkg::seg_ctl_t ctl,
	output arqfrs_pkg::seg_res_t res
);

	logic [31:0] margin;
	logic [31:0] elapsed;
	logic        timed_out;
	logic [31:0] inc;
	logic [32:0] tmo_sum;
	logic [7:0]  cnt_inc;
	logic        fast_hit;

	assign margin    = ctl.no_delay ? 32'd0 : {19'd0, item.base_timeout[15:3]};
	assign elapsed   = ctl.now - item.seg_resend_time;
	assign timed_out = !elapsed[31];
	assign inc       = ctl.no_delay ? {17'd0, item.base_timeout[15:1]}
		: {16'd0, item.base_timeout};
	assign tmo_sum   = {1'b0, item.seg_timeout} + {1'b0, inc};
	assign cnt_inc   = (item.seg_send_count == 8'hff) ? 8'hff : item.seg_send_count + 8'd1;
	assign fast_hit  = (ctl.fast_acks != 8'd0) && (item.seg_skip_acks >= ctl.fast_acks);

	always_comb begin
		res.send = 1'b0;
		res.cnt  = item.seg_send_count;
		res.tmo  = item.seg_timeout;
		res.due  = item.seg_resend_time;
		res.skip = item.seg_skip_acks;
		res.loss = 1'b0;
		res.fast = 1'b0;
		if (ctl.started) begin
			priority if (item.seg_send_count == 8'd0) begin
				res.send = 1'b1;
				res.cnt  = 8'd1;
				res.tmo  = {16'd0, item.base_timeout};
				res.due  = ctl.now + {16'd0, item.base_timeout} + margin;
			end else if (timed_out) begin
				res.send = 1'b1;
				res.cnt  = cnt_inc;
				res.loss = 1'b1;
				// On saturation the due time is the current time plus all ones.
				if (tmo_sum[32]) begin
					res.tmo = 32'hffff_ffff;
					res.due = ctl.now - 32'd1;
				end else begin
					res.tmo = tmo_sum[31:0];
					res.due = ctl.now + item.seg_timeout + inc;
				end
			end else if (fast_hit) begin
				res.send = 1'b1;
				res.cnt  = cnt_inc;
				res.skip = 8'd0;
				res.due  = ctl.now + item.seg_timeout;
				res.fast = 1'b1;
			end else begin
				// Not due yet: the counters are passed through unchanged.
			end
		end
		res.dead = res.send && (res.cnt >= ctl.dead_sends);
	end

endmodule

[hdl/arq_flush_retransmit_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Retransmit scheduler top level
// Flush timer, zero-window probe backoff, segment send decisions and the
// congestion cuts applied at the end of a flush.
// ----------------------------------------------------------------------------
// Usage: the host sends beats on the item channel. A tick beat carries the
// time and the peer window; a segment check beat carries one buffered
// segment's counters; an end-of-flush beat carries the in-flight count.
// Every accepted beat yields exactly one result beat on the result channel,
// in order. Registers are written on the cfg channel, which is always ready;
// writes are expected only while no beat is in flight.
// An accepted beat is registered in the input stage, and its result is then
// registered in the result register. Throughput is one beat per cycle while
// the result receiver does not stall; the whole decision is a single pass of
// compare, add and multiply logic between the input stage and the result register.
// Reset clears both stages, restores the register defaults and puts the
// scheduler in its not-started state. When the result receiver stalls, the
// result register holds, the input stage fills, and the item channel drops
// ready only once both stages are occupied.
// ----------------------------------------------------------------------------
`include "arq_flush_retransmit_scheduler_defines.svh"

module arq_flush_retransmit_scheduler (
	input  logic               clk,
	input  logic               arst_n,
	arqfrs_item_if.sink        item,
	arqfrs_result_if.source    result,
	arqfrs_cfg_if.sink         cfg
);

	// Configuration registers.
	logic        no_delay_q;
	logic [12:0] flush_ivl_q;
	logic [7:0]  fast_acks_q;
	logic        no_cong_q;
	logic [15:0] send_win_q;
	logic [7:0]  dead_sends_q;
	logic [15:0] mss_q;

	// Scheduler state.
	logic        started_q;
	logic [31:0] cur_time_q;
	logic [31:0] next_flush_q;
	logic [16:0] probe_wait_q;
	logic [31:0] probe_due_q;
	logic [15:0] latched_win_q;
	logic        loss_q;
	logic        fast_q;
	logic [15:0] cwnd_q;
	logic [15:0] ssthresh_q;
	logic [31:0] credit_q;
	logic        dead_q;

	// Input stage and result register.
	logic                valid_s1;
	arqfrs_pkg::item_t   data_s1;
	logic                out_valid_q;
	arqfrs_pkg::result_t out_q;
	logic                advance;

	// The input stage moves on when the result register is free or drains.
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready   = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			data_s1 <= item.data;
		end
	end

	// Flush interval writes are clamped into the legal range.
	logic [12:0] ivl_wr;

	always_comb begin
		ivl_wr = cfg.data[12:0];
		if (ivl_wr > arqfrs_pkg::FLUSH_IVL_MAX) begin
			ivl_wr = arqfrs_pkg::FLUSH_IVL_MAX;
		end
		if (ivl_wr < arqfrs_pkg::FLUSH_IVL_MIN) begin
			ivl_wr = arqfrs_pkg::FLUSH_IVL_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_delay_q   <= 1'b0;
			flush_ivl_q  <= arqfrs_pkg::FLUSH_IVL_RST;
			fast_acks_q  <= 8'd0;
			no_cong_q    <= 1'b0;
			send_win_q   <= arqfrs_pkg::SEND_WINDOW_RST;
			dead_sends_q <= arqfrs_pkg::DEAD_SENDS_RST;
			mss_q        <= arqfrs_pkg::MSS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				arqfrs_pkg::REG_NO_DELAY: begin
					no_delay_q <= cfg.data[0];
				end
				arqfrs_pkg::REG_FLUSH_IVL: begin
					flush_ivl_q <= ivl_wr;
				end
				arqfrs_pkg::REG_FAST_ACKS: begin
					fast_acks_q <= cfg.data[7:0];
				end
				arqfrs_pkg::REG_NO_CONGESTION: begin
					no_cong_q <= cfg.data[0];
				end
				arqfrs_pkg::REG_SEND_WINDOW: begin
					// A zero send window is not accepted.
					if (cfg.data != '0) begin
						send_win_q <= cfg.data;
					end
				end
				arqfrs_pkg::REG_DEAD_SENDS: begin
					dead_sends_q <= cfg.data[7:0];
				end
				arqfrs_pkg::REG_MSS: begin
					mss_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Tick: wrap-safe flush timer. Time differences are taken modulo 2^32
	// and read as signed, so the timer survives the millisecond counter
	// wrapping. A schedule that lags the current time by ten seconds or more,
	// or leads it by more than ten seconds, is pulled back to the current time.
	// ------------------------------------------------------------------
	logic [31:0]        now;
	logic [31:0]        nf_base;
	logic signed [31:0] slap;
	logic               resync;
	logic               flush_due;
	logic [31:0]        nf_step;
	logic [31:0]        nf_check;
	logic [31:0]        nf_tick;

	assign now       = data_s1.now_ms;
	assign nf_base   = started_q ? next_flush_q : now;
	assign slap      = $signed(now - nf_base);
	assign resync    = (slap >= arqfrs_pkg::RESYNC_MS) || (slap < -arqfrs_pkg::RESYNC_MS);
	assign flush_due = resync || !slap[31];
	assign nf_step   = (resync ? now : nf_base) + {19'd0, flush_ivl_q};
	assign nf_check  = now - nf_step;
	// If the schedule is still behind after one step, restart from now.
	assign nf_tick   = flush_due ? (nf_check[31] ? nf_step : now + {19'd0, flush_ivl_q})
		: nf_base;

	// Zero-window probe backoff: 7 s first wait, then grow by half each
	// time the wait expires, capped at 120 s.
	logic [31:0] probe_elapsed;
	logic [17:0] probe_lo;
	logic [17:0] probe_grow;
	logic [17:0] probe_next;
	logic [16:0] probe_wait_tick;
	logic [31:0] probe_due_tick;
	logic        ask_tick;

	assign probe_elapsed = now - probe_due_q;
	assign probe_lo      = ({1'b0, probe_wait_q} < arqfrs_pkg::PROBE_FIRST_MS)
		? arqfrs_pkg::PROBE_FIRST_MS : {1'b0, probe_wait_q};
	assign probe_grow    = probe_lo + {1'b0, probe_lo[17:1]};
	assign probe_next    = (probe_grow > arqfrs_pkg::PROBE_MAX_MS)
		? arqfrs_pkg::PROBE_MAX_MS : probe_grow;

	always_comb begin
		probe_wait_tick = probe_wait_q;
		probe_due_tick  = probe_due_q;
		ask_tick        = 1'b0;
		if (data_s1.remote_window == 16'd0) begin
			priority if (probe_wait_q == 17'd0) begin
				probe_wait_tick = arqfrs_pkg::PROBE_FIRST_MS[16:0];
				probe_due_tick  = now + {14'd0, arqfrs_pkg::PROBE_FIRST_MS};
			end else if (!probe_elapsed[31]) begin
				probe_wait_tick = probe_next[16:0];
				probe_due_tick  = now + {14'd0, probe_next};
				ask_tick        = 1'b1;
			end else begin
				// The current probe wait has not run out yet.
			end
		end else begin
			probe_wait_tick = 17'd0;
			probe_due_tick  = 32'd0;
		end
	end

	// Effective window: local and peer windows, and the congestion window
	// unless congestion control is switched off.
	logic [15:0] win_peer;
	logic [15:0] win_tick;

	assign win_peer = (send_win_q < data_s1.remote_window) ? send_win_q : data_s1.remote_window;
	assign win_tick = (!no_cong_q && (cwnd_q < win_peer)) ? cwnd_q : win_peer;

	// ------------------------------------------------------------------
	// Segment check.
	// ------------------------------------------------------------------
	arqfrs_pkg::seg_ctl_t seg_ctl;
	arqfrs_pkg::seg_res_t seg_res;

	assign seg_ctl.started    = started_q;
	assign seg_ctl.now        = cur_time_q;
	assign seg_ctl.no_delay   = no_delay_q;
	assign seg_ctl.fast_acks  = fast_acks_q;
	assign seg_ctl.dead_sends = dead_sends_q;

	arqfrs_seg_eval u_seg_eval (
		.item (data_s1),
		.ctl  (seg_ctl),
		.res  (seg_res)
	);

	// ------------------------------------------------------------------
	// End of flush: a fast resend halves the threshold from the in-flight
	// count and opens the window by the fast-resend count; a loss halves
	// the threshold from the latched window and collapses the window to one
	// segment. A loss wins when both happened; with neither, a shut window opens to one segment.
	// ------------------------------------------------------------------
	logic [15:0] ss_fast;
	logic [16:0] cw_sum;
	logic [15:0] cw_fast;
	logic [31:0] credit_fast;
	logic [15:0] ss_loss;

	assign ss_fast     = (data_s1.in_flight[15:1] < arqfrs_pkg::THRESH_FLOOR)
		? arqfrs_pkg::THRESH_FLOOR : {1'b0, data_s1.in_flight[15:1]};
	assign cw_sum      = {1'b0, ss_fast} + {9'd0, fast_acks_q};
	// With fast resend off the opening is all ones, so the window saturates.
	assign cw_fast     = ((fast_acks_q == 8'd0) || cw_sum[16]) ? 16'hffff : cw_sum[15:0];
	assign credit_fast = {16'd0, cw_fast} * {16'd0, mss_q};
	assign ss_loss     = (latched_win_q[15:1] < arqfrs_pkg::THRESH_FLOOR)
		? arqfrs_pkg::THRESH_FLOOR : {1'b0, latched_win_q[15:1]};

	// ------------------------------------------------------------------
	// Next state and result.
	// ------------------------------------------------------------------
	logic                started_d;
	logic [31:0]         cur_time_d;
	logic [31:0]         next_flush_d;
	logic [16:0]         probe_wait_d;
	logic [31:0]         probe_due_d;
	logic [15:0]         latched_win_d;
	logic                loss_d;
	logic                fast_d;
	logic [15:0]         cwnd_d;
	logic [15:0]         ssthresh_d;
	logic [31:0]         credit_d;
	logic                dead_d;
	arqfrs_pkg::result_t res_d;

	always_comb begin
		started_d     = started_q;
		cur_time_d    = cur_time_q;
		next_flush_d  = next_flush_q;
		probe_wait_d  = probe_wait_q;
		probe_due_d   = probe_due_q;
		latched_win_d = latched_win_q;
		loss_d        = loss_q;
		fast_d        = fast_q;
		cwnd_d        = cwnd_q;
		ssthresh_d    = ssthresh_q;
		credit_d      = credit_q;
		dead_d        = dead_q;
		res_d         = '0;

		unique case (data_s1.action)
			arqfrs_pkg::ACT_TICK: begin
				started_d    = 1'b1;
				cur_time_d   = now;
				next_flush_d = nf_tick;
				if (flush_due) begin
					res_d.flush_now        = 1'b1;
					res_d.ask_window_probe = ask_tick;
					loss_d        = 1'b0;
					fast_d        = 1'b0;
					probe_wait_d  = probe_wait_tick;
					probe_due_d   = probe_due_tick;
					latched_win_d = win_tick;
				end
			end
			arqfrs_pkg::ACT_SEG: begin
				res_d.need_send       = seg_res.send;
				res_d.new_send_count  = seg_res.cnt;
				res_d.new_timeout     = seg_res.tmo;
				res_d.new_resend_time = seg_res.due;
				res_d.new_skip_acks   = seg_res.skip;
				loss_d = loss_q || seg_res.loss;
				fast_d = fast_q || seg_res.fast;
				dead_d = dead_q || seg_res.dead;
			end
			arqfrs_pkg::ACT_END: begin
				if (started_q) begin
					priority if (loss_q) begin
						ssthresh_d = ss_loss;
						cwnd_d     = 16'd1;
						credit_d   = {16'd0, mss_q};
					end else if (fast_q) begin
						ssthresh_d = ss_fast;
						cwnd_d     = cw_fast;
						credit_d   = credit_fast;
					end else if (cwnd_q == 16'd0) begin
						cwnd_d   = 16'd1;
						credit_d = {16'd0, mss_q};
					end else begin
						// No cut was called for and the window is open.
					end
				end
			end
			default: begin
			end
		endcase

		res_d.link_dead            = dead_d;
		res_d.effective_window     = latched_win_d;
		res_d.congestion_window    = cwnd_d;
		res_d.slow_start_threshold = ssthresh_d;
		res_d.byte_credit          = credit_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q     <= 1'b0;
			cur_time_q    <= 32'd0;
			next_flush_q  <= arqfrs_pkg::NEXT_FLUSH_RST;
			probe_wait_q  <= 17'd0;
			probe_due_q   <= 32'd0;
			latched_win_q <= 16'd0;
			loss_q        <= 1'b0;
			fast_q        <= 1'b0;
			cwnd_q        <= 16'd0;
			ssthresh_q    <= arqfrs_pkg::THRESH_FLOOR;
			credit_q      <= 32'd0;
			dead_q        <= 1'b0;
		end else if (advance) begin
			started_q     <= started_d;
			cur_time_q    <= cur_time_d;
			next_flush_q  <= next_flush_d;
			probe_wait_q  <= probe_wait_d;
			probe_due_q   <= probe_due_d;
			latched_win_q <= latched_win_d;
			loss_q        <= loss_d;
			fast_q        <= fast_d;
			cwnd_q        <= cwnd_d;
			ssthresh_q    <= ssthresh_d;
			credit_q      <= credit_d;
			dead_q        <= dead_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_d;
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	logic ss_ok;
	logic probe_ok;
	logic ivl_ok;
	logic s1_stall;

	assign ss_ok    = ssthresh_q >= arqfrs_pkg::THRESH_FLOOR;
	assign probe_ok = {1'b0, probe_wait_q} <= arqfrs_pkg::PROBE_MAX_MS;
	assign ivl_ok   = (flush_ivl_q >= arqfrs_pkg::FLUSH_IVL_MIN)
		&& (flush_ivl_q <= arqfrs_pkg::FLUSH_IVL_MAX);
	assign s1_stall = valid_s1 && !advance;

	`ARQFRS_ASSERT_ALWAYS(a_ssthresh_floor, clk, arst_n, ss_ok, "threshold below floor")
	`ARQFRS_ASSERT_ALWAYS(a_probe_cap, clk, arst_n, probe_ok, "probe wait above cap")
	`ARQFRS_ASSERT_ALWAYS(a_ivl_range, clk, arst_n, ivl_ok, "flush interval out of range")
	`ARQFRS_ASSERT_NEXT(a_dead_sticky, clk, arst_n, dead_q, dead_q, "dead link flag cleared")
	`ARQFRS_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_stall, valid_s1 && $stable(data_s1), "beat lost")

endmodule
